[hdl/rpmt_pkg.sv]
// rpmt_pkg: shared types, codes and default sizes for the route prefix match table.
// Used by route_prefix_match_table_core; depends on nothing else.
package rpmt_pkg;

    localparam int MAX_ROUTES_DEF    = 32;
    localparam int MAX_ROUTE_LEN_DEF = 64;
    localparam int TARGET_BITS_DEF   = 16;

    // item mode codes
    localparam logic MODE_BIND   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // result kind codes
    localparam logic KIND_BIND   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // bind status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [7:0]  char_byte;
        logic        last;
        logic [15:0] target_id;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic        matched;
        logic [4:0]  route_index;
        logic [15:0] found_target;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PICK,
        ST_TGT
    } state_t;

endpackage

[hdl/route_prefix_match_table_core.sv]
// route_prefix_match_table_core: prefix-matched route table with byte-lane route memory.
// Depends on rpmt_pkg (types, codes, default sizes).
//
//  channel   signals                           direction  payload
//  item      item_valid / item_stall / item    in         rpmt_pkg::item_t
//  result    result_valid / result_stall / result  out    rpmt_pkg::result_t
//  config    cfg_write_en / cfg_write_data     in         last_wins (1 bit)
//
// Steps: a bind byte or a non-final lookup byte goes through a route row read, then
// compare or byte write. A final lookup byte goes on to compare, pick encode and
// target read. Both memories have registered reads and are not cleared on reset.
// Reset clears route count, position and output valid, and sets the alive mask to ones.
// item_stall is high while an item is in flight; a final byte stays in flight while the
// previous result waits on result_stall.
module route_prefix_match_table_core #(
    parameter int MAX_ROUTES    = rpmt_pkg::MAX_ROUTES_DEF,
    parameter int MAX_ROUTE_LEN = rpmt_pkg::MAX_ROUTE_LEN_DEF,
    parameter int TARGET_BITS   = rpmt_pkg::TARGET_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  rpmt_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output rpmt_pkg::result_t result,
    input  logic              cfg_write_en,
    input  logic              cfg_write_data
);

    localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CNT_W = $clog2(MAX_ROUTES + 1);
    localparam int ROW_W = $clog2(MAX_ROUTE_LEN);
    localparam int LEN_W = $clog2(MAX_ROUTE_LEN + 1);

    rpmt_pkg::state_t  state_reg, state_next;
    rpmt_pkg::item_t   item_reg;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [MAX_ROUTES-1:0] alive_reg, alive_next;
    logic              too_long_reg, too_long_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              last_wins_reg;
    logic [MAX_ROUTES-1:0] match_reg, match_next;
    logic [IDX_W-1:0]  pick_reg;
    logic              found_reg;
    logic              out_valid_reg, out_valid_next;
    rpmt_pkg::result_t out_reg, out_next;

    // memories
    logic [7:0]             byte_mem [MAX_ROUTE_LEN][MAX_ROUTES];
    logic [7:0]             row_q    [MAX_ROUTES];
    logic [TARGET_BITS-1:0] tgt_mem  [MAX_ROUTES];
    logic [TARGET_BITS-1:0] tgt_q;
    logic [LEN_W-1:0]       len_reg  [MAX_ROUTES];

    logic              accept;
    logic              slot_free;
    logic              byte_we;
    logic              commit;
    logic              pos_in_range;
    logic [LEN_W-1:0]  pos_sat;
    logic [MAX_ROUTES-1:0] valid_mask;
    logic [MAX_ROUTES-1:0] kill;
    logic [IDX_W-1:0]  pick_c;
    logic              found_c;
    logic [31:0]       tgt_in_wide;
    logic [31:0]       tgt_out_wide;
    logic [31:0]       pick_wide;

    assign item_stall   = (state_reg != rpmt_pkg::ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign slot_free    = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign pos_in_range = (pos_reg < LEN_W'(MAX_ROUTE_LEN));
    assign pos_sat      = pos_in_range ? (pos_reg + LEN_W'(1)) : pos_reg;
    assign tgt_in_wide  = 32'(item_reg.target_id);
    assign tgt_out_wide = 32'(tgt_q);
    assign pick_wide    = 32'(pick_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_ROUTES; i++)
        begin
            valid_mask[i] = (CNT_W'(i) < count_reg);
            kill[i] = valid_mask[i] && pos_in_range && (pos_reg < len_reg[i])
                      && (row_q[i] != item_reg.char_byte);
        end
    end

    // first or last set bit of the match vector
    always_comb
    begin
        pick_c  = '0;
        found_c = 1'b0;
        for (int i = 0; i < MAX_ROUTES; i++)
        begin
            if (match_reg[i] && (!found_c || last_wins_reg))
            begin
                pick_c = IDX_W'(i);
            end
            if (match_reg[i])
            begin
                found_c = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        alive_next     = alive_reg;
        too_long_next  = too_long_reg;
        count_next     = count_reg;
        match_next     = match_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        byte_we        = 1'b0;
        commit         = 1'b0;

        case (state_reg)
            rpmt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = rpmt_pkg::ST_EXEC;
                end
            end
            rpmt_pkg::ST_EXEC:
            begin
                if (item_reg.mode == rpmt_pkg::MODE_BIND)
                begin
                    if (!item_reg.last || slot_free)
                    begin
                        state_next    = rpmt_pkg::ST_IDLE;
                        pos_next      = pos_sat;
                        too_long_next = too_long_reg || !pos_in_range;
                        byte_we       = pos_in_range && (count_reg < CNT_W'(MAX_ROUTES));
                        if (item_reg.last)
                        begin
                            out_valid_next       = 1'b1;
                            out_next             = '0;
                            out_next.kind        = rpmt_pkg::KIND_BIND;
                            if (too_long_next)
                            begin
                                out_next.status = rpmt_pkg::STATUS_TOO_LONG;
                            end
                            else if (count_reg >= CNT_W'(MAX_ROUTES))
                            begin
                                out_next.status = rpmt_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                out_next.status = rpmt_pkg::STATUS_OK;
                                commit          = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                            end
                            pos_next      = '0;
                            alive_next    = '1;
                            too_long_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    pos_next   = pos_sat;
                    alive_next = alive_reg & ~kill;
                    state_next = rpmt_pkg::ST_IDLE;
                    if (item_reg.last)
                    begin
                        for (int i = 0; i < MAX_ROUTES; i++)
                        begin
                            match_next[i] = alive_next[i] && valid_mask[i]
                                            && (len_reg[i] <= pos_sat);
                        end
                        pos_next      = '0;
                        alive_next    = '1;
                        too_long_next = 1'b0;
                        state_next    = rpmt_pkg::ST_PICK;
                    end
                end
            end
            rpmt_pkg::ST_PICK:
            begin
                state_next = rpmt_pkg::ST_TGT;
            end
            rpmt_pkg::ST_TGT:
            begin
                if (slot_free)
                begin
                    state_next             = rpmt_pkg::ST_IDLE;
                    out_valid_next         = 1'b1;
                    out_next               = '0;
                    out_next.kind          = rpmt_pkg::KIND_LOOKUP;
                    out_next.status        = rpmt_pkg::STATUS_OK;
                    out_next.matched       = found_reg;
                    if (found_reg)
                    begin
                        out_next.route_index  = pick_wide[4:0];
                        out_next.found_target = tgt_out_wide[15:0];
                    end
                end
            end
            default:
            begin
                state_next = rpmt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rpmt_pkg::ST_IDLE;
            pos_reg        <= '0;
            alive_reg      <= '1;
            too_long_reg   <= 1'b0;
            count_reg      <= '0;
            last_wins_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            alive_reg     <= alive_next;
            too_long_reg  <= too_long_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                last_wins_reg <= cfg_write_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        match_reg <= match_next;
        out_reg   <= out_next;
        if (state_reg == rpmt_pkg::ST_PICK)
        begin
            pick_reg  <= pick_c;
            found_reg <= found_c;
        end
        if (commit)
        begin
            len_reg[count_reg[IDX_W-1:0]] <= pos_sat;
        end
    end

    // route bytes: one row per position, one byte lane per entry
    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_mem[pos_reg[ROW_W-1:0]][count_reg[IDX_W-1:0]] <= item_reg.char_byte;
        end
        if (accept)
        begin
            row_q <= byte_mem[pos_reg[ROW_W-1:0]];
        end
    end

    // route targets
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            tgt_mem[count_reg[IDX_W-1:0]] <= tgt_in_wide[TARGET_BITS-1:0];
        end
        if (state_reg == rpmt_pkg::ST_PICK)
        begin
            tgt_q <= tgt_mem[pick_c];
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ROUTES))
        else $error("route count past table size");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LEN_W'(MAX_ROUTE_LEN))
        else $error("char position past saturation");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1)) && out_valid_reg &&
            (out_reg.kind == rpmt_pkg::KIND_BIND) &&
            (out_reg.status == rpmt_pkg::STATUS_OK))
        else $error("route count moved without a bind transfer");

    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == rpmt_pkg::KIND_LOOKUP) && !out_reg.matched) |->
            (out_reg.route_index == 5'd0) && (out_reg.found_target == 16'd0))
        else $error("lookup miss with nonzero index or target");
`endif

endmodule

[verif/route_prefix_match_table_core_tb.sv]
`timescale 1ns / 100ps
// route_prefix_match_table_core_tb: self-checking bench for the route prefix match table core.
// Depends on rpmt_pkg and route_prefix_match_table_core; an in-bench model predicts each result.

module route_prefix_match_table_core_tb;

    localparam int TABLE_DEPTH      = rpmt_pkg::MAX_ROUTES_DEF;
    localparam int ROUTE_MAX        = rpmt_pkg::MAX_ROUTE_LEN_DEF;
    localparam int IDLE_LIMIT       = 4000;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 12;
    localparam int RANDOM_TRANSFERS = 1720;
    localparam int RANDOM_CHUNKS    = 8;
    localparam int REPORT_MAX       = 10;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    rpmt_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    rpmt_pkg::result_t result;
    logic              cfg_write_en;
    logic              cfg_write_data;

    // prediction state
    logic [7:0]             tbl_bytes [TABLE_DEPTH][ROUTE_MAX];
    int                     tbl_len [TABLE_DEPTH];
    logic [15:0]            tbl_target [TABLE_DEPTH];
    int                     tbl_count;
    int                     scan_pos;
    logic [TABLE_DEPTH-1:0] alive_mask;
    bit                     bind_overflow;
    logic                   pick_last;

    rpmt_pkg::result_t pending_results[$];
    logic [7:0]  text_buf[$];
    int          mismatches;
    int          transfers_sent;
    int          idle_cycles;
    int          burst_left;
    bit          gaps_off;
    bit          hold_request;
    int          hold_left;
    int          stall_style;
    int          style_left;
    int          stall_phase;

    route_prefix_match_table_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void predict_transfer(input rpmt_pkg::item_t it);
        rpmt_pkg::result_t r;
        int      p;
        int      i;
        int      pick;
        bit      hit;
        p = scan_pos;
        if (it.mode == rpmt_pkg::MODE_BIND)
        begin
            if (p >= ROUTE_MAX)
                bind_overflow = 1'b1;
            else if (tbl_count < TABLE_DEPTH)
                tbl_bytes[tbl_count][p] = it.char_byte;
        end
        else
        begin
            for (i = 0; i < tbl_count; i++)
                if (p < tbl_len[i] && p < ROUTE_MAX && tbl_bytes[i][p] != it.char_byte)
                    alive_mask[i] = 1'b0;
        end
        scan_pos = (p < ROUTE_MAX) ? p + 1 : ROUTE_MAX;
        if (!it.last)
            return;

        r = '0;
        hit = 1'b0;
        pick = 0;
        if (it.mode == rpmt_pkg::MODE_BIND)
        begin
            r.kind = rpmt_pkg::KIND_BIND;
            if (bind_overflow)
                r.status = rpmt_pkg::STATUS_TOO_LONG;
            else if (tbl_count >= TABLE_DEPTH)
                r.status = rpmt_pkg::STATUS_FULL;
            else
            begin
                r.status = rpmt_pkg::STATUS_OK;
                tbl_len[tbl_count] = scan_pos;
                tbl_target[tbl_count] = it.target_id;
                tbl_count++;
            end
        end
        else
        begin
            r.kind = rpmt_pkg::KIND_LOOKUP;
            r.status = rpmt_pkg::STATUS_OK;
            for (i = 0; i < tbl_count; i++)
            begin
                if (alive_mask[i] && tbl_len[i] <= scan_pos)
                begin
                    if (!hit || pick_last)
                        pick = i;
                    hit = 1'b1;
                end
            end
            if (hit)
            begin
                r.matched = 1'b1;
                r.route_index = pick[4:0];
                r.found_target = tbl_target[pick];
            end
        end
        pending_results.push_back(r);
        scan_pos = 0;
        alive_mask = '1;
        bind_overflow = 1'b0;
    endfunction

    task automatic check_result(input rpmt_pkg::result_t got);
        rpmt_pkg::result_t want;
        bit      bad;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("unexpected result: kind=%0d status=%0d matched=%0d index=%0d target=%h",
                         got.kind, got.status, got.matched, got.route_index, got.found_target);
        end
        else
        begin
            want = pending_results.pop_front();
            bad = (got.kind !== want.kind) || (got.status !== want.status) ||
                  (got.matched !== want.matched) || (got.route_index !== want.route_index) ||
                  (got.found_target !== want.found_target);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("mismatch exp: kind=%0d status=%0d matched=%0d index=%0d target=%h",
                             want.kind, want.status, want.matched, want.route_index,
                             want.found_target);
                    $display("         got: kind=%0d status=%0d matched=%0d index=%0d target=%h",
                             got.kind, got.status, got.matched, got.route_index,
                             got.found_target);
                end
            end
        end
    endtask

    // result checker and no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_result(result);
        if (rst_n && ((item_valid && !item_stall) || (result_valid && !result_stall)))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver stall pattern, with an occasional long hold-off on request
    always @(posedge clk)
    begin
        stall_phase++;
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else
        begin
            if (style_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                style_left = $urandom_range(20, 200);
            end
            else
                style_left--;
            case (stall_style)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ($urandom_range(0, 9) < 7);
                default: result_stall <= (stall_phase % 3 == 0);
            endcase
        end
    end

    task automatic send_transfer(input rpmt_pkg::item_t it);
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_transfer(it);
        transfers_sent++;
        if (!gaps_off)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(0, 30);
            end
        end
    endtask

    // sends text_buf as one route or URL; the byte at flip_at carries the other mode
    task automatic send_text(input logic m, input logic [15:0] tgt, input int flip_at);
        rpmt_pkg::item_t it;
        int    k;
        for (k = 0; k < text_buf.size(); k++)
        begin
            it.mode = (k == flip_at) ? ~m : m;
            it.char_byte = text_buf[k];
            it.last = (k == text_buf.size() - 1);
            it.target_id = it.last ? tgt : 16'($urandom);
            send_transfer(it);
        end
    endtask

    task automatic wait_idle();
        if (item_valid)
            item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_match_mode(input logic m);
        wait_idle();
        cfg_write_en <= 1'b1;
        cfg_write_data <= m;
        @(posedge clk);
        pick_last = m;
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [7:0] rand_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'h2f;
            3, 4, 5: return 8'h61;
            6, 7:    return 8'h62;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic fill_random(input int n);
        int k;
        for (k = 0; k < n; k++)
            text_buf.push_back(rand_char());
    endtask

    task automatic fill_from_route(input int idx, input int n);
        int k;
        for (k = 0; k < n && k < tbl_len[idx]; k++)
            text_buf.push_back(tbl_bytes[idx][k]);
    endtask

    task automatic random_item();
        int pick;
        int idx;
        int n;
        int k;
        text_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            n = $urandom_range(0, 99);
            if (n < 8)
                fill_random(ROUTE_MAX + $urandom_range(0, 1) * $urandom_range(1, 6));
            else if (tbl_count > 0 && n < 50)
            begin
                idx = $urandom_range(0, tbl_count - 1);
                fill_from_route(idx, tbl_len[idx]);
                fill_random($urandom_range(0, 3));
            end
            else
                fill_random($urandom_range(1, 6));
            send_text(rpmt_pkg::MODE_BIND, 16'($urandom), -1);
        end
        else if (pick < 75 && tbl_count > 0)
        begin
            // URL built around a bound route: exact, extended, cut short or with one byte changed
            idx = $urandom_range(0, tbl_count - 1);
            fill_from_route(idx, tbl_len[idx] - $urandom_range(0, 1) * $urandom_range(0, 2));
            fill_random($urandom_range(0, 6));
            if (text_buf.size() == 0)
                text_buf.push_back(rand_char());
            if ($urandom_range(0, 4) == 0)
                text_buf[$urandom_range(0, text_buf.size() - 1)] = rand_char();
            send_text(rpmt_pkg::MODE_LOOKUP, 16'($urandom), -1);
        end
        else if (pick < 82)
        begin
            // URL running past the longest route
            if (tbl_count > 0)
            begin
                idx = $urandom_range(0, tbl_count - 1);
                fill_from_route(idx, tbl_len[idx]);
            end
            n = ROUTE_MAX + $urandom_range(1, 8);
            fill_random(n - text_buf.size());
            send_text(rpmt_pkg::MODE_LOOKUP, 16'($urandom), -1);
        end
        else if (pick < 90)
        begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
                text_buf.push_back(8'($urandom_range(1, 255)));
            send_text(rpmt_pkg::MODE_LOOKUP, 16'($urandom), -1);
        end
        else
        begin
            // mixed modes, kept so that no committed route has an unwritten byte
            case ($urandom_range(0, 2))
                0:
                begin
                    if (tbl_count > 0)
                    begin
                        idx = $urandom_range(0, tbl_count - 1);
                        fill_from_route(idx, tbl_len[idx]);
                    end
                    fill_random($urandom_range(1, 4));
                    if (text_buf.size() < 2)
                        text_buf.push_back(rand_char());
                    send_text(rpmt_pkg::MODE_LOOKUP, 16'($urandom),
                              $urandom_range(0, text_buf.size() - 2));
                end
                1:
                begin
                    fill_random($urandom_range(2, 6));
                    send_text(rpmt_pkg::MODE_BIND, 16'($urandom), text_buf.size() - 1);
                end
                default:
                begin
                    fill_random(ROUTE_MAX + $urandom_range(1, 4));
                    send_text(rpmt_pkg::MODE_BIND, 16'($urandom),
                              $urandom_range(0, ROUTE_MAX - 1));
                end
            endcase
        end
    endtask

    task automatic test_empty_lookup();
        text_buf = '{8'hff};
        send_text(rpmt_pkg::MODE_LOOKUP, 16'h0000, -1);
    endtask

    task automatic test_bind_basic();
        text_buf = '{8'h2f};
        send_text(rpmt_pkg::MODE_BIND, 16'hffff, -1);
        text_buf = '{8'h2f, 8'h61};
        send_text(rpmt_pkg::MODE_BIND, 16'h0000, -1);
        text_buf = '{8'h2f};
        send_text(rpmt_pkg::MODE_BIND, 16'h1234, -1);
        // a zero byte is an ordinary character
        text_buf = '{8'h00, 8'hff, 8'h01};
        send_text(rpmt_pkg::MODE_BIND, 16'h8001, -1);
    endtask

    task automatic test_pick_mode();
        text_buf = '{8'h2f, 8'h61, 8'h62};
        send_text(rpmt_pkg::MODE_LOOKUP, 16'h0000, -1);
        set_match_mode(1'b1);
        text_buf = '{8'h2f, 8'h61, 8'h62};
        send_text(rpmt_pkg::MODE_LOOKUP, 16'h0000, -1);
        text_buf = '{8'h2f};
        send_text(rpmt_pkg::MODE_LOOKUP, 16'h0000, -1);
        text_buf = '{8'h00, 8'hff, 8'h01, 8'h7e};
        send_text(rpmt_pkg::MODE_LOOKUP, 16'h0000, -1);
    endtask

    // receiver holds off while the sender keeps offering; the core has to stall its input
    task automatic test_backpressure();
        int k;
        gaps_off = 1'b1;
        hold_request = 1'b1;
        for (k = 0; k < 12; k++)
        begin
            text_buf.delete();
            text_buf.push_back(rand_char());
            send_text(rpmt_pkg::MODE_LOOKUP, 16'h0000, -1);
        end
        gaps_off = 1'b0;
    endtask

    task automatic test_random();
        int chunk;
        int goal;
        for (chunk = 0; chunk < RANDOM_CHUNKS; chunk++)
        begin
            set_match_mode(chunk[0]);
            goal = transfers_sent + RANDOM_TRANSFERS / RANDOM_CHUNKS;
            while (transfers_sent < goal)
                random_item();
        end
    endtask

    task automatic test_capacity();
        while (tbl_count < TABLE_DEPTH)
        begin
            text_buf.delete();
            fill_random($urandom_range(1, 4));
            send_text(rpmt_pkg::MODE_BIND, 16'($urandom), -1);
        end
        // too long wins over table full
        text_buf.delete();
        fill_random(ROUTE_MAX + 3);
        send_text(rpmt_pkg::MODE_BIND, 16'($urandom), -1);
        text_buf.delete();
        fill_random(2);
        send_text(rpmt_pkg::MODE_BIND, 16'($urandom), -1);
        text_buf.delete();
        fill_from_route(0, tbl_len[0]);
        fill_random(ROUTE_MAX + 8 - text_buf.size());
        send_text(rpmt_pkg::MODE_LOOKUP, 16'h0000, -1);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        result_stall <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_write_data <= 1'b0;
        tbl_count = 0;
        scan_pos = 0;
        alive_mask = '1;
        bind_overflow = 1'b0;
        pick_last = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_lookup();
        test_bind_basic();
        test_pick_mode();
        test_backpressure();
        test_random();
        test_capacity();

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
